// ===== hdl/ssp_pkg.sv =====
// Shared constants, types and pattern tables for the SQL statement splitter.
package ssp_pkg;

    localparam int HIST_LEN    = 27;
    localparam int DEPTH_LIMIT = 255;
    localparam int DEPTH_W     = $clog2(DEPTH_LIMIT + 1);
    localparam int LEN_W       = 5;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;

    localparam int TRIG_LEN  = 14;
    localparam int BEGIN_LEN = 5;
    localparam int CASE_LEN  = 4;
    localparam int END_LEN   = 3;
    localparam int MARK_LEN  = 28;

    // Last pattern character sits in the lowest byte, matching the window order.
    localparam logic [8*TRIG_LEN-1:0]  KW_TRIGGER = "CREATE TRIGGER";
    localparam logic [8*BEGIN_LEN-1:0] KW_BEGIN   = "BEGIN";
    localparam logic [8*CASE_LEN-1:0]  KW_CASE    = "CASE";
    localparam logic [8*END_LEN-1:0]   KW_END     = "END";
    // Table marker; the table name is spelled out as byte codes.
    localparam logic [8*MARK_LEN-1:0]  TBL_MARKER = {"CREATE TABLE ",
        8'h73, 8'h71, 8'h6c, 8'h69, 8'h74, 8'h65, 8'h5f, 8'h73,
        8'h65, 8'h71, 8'h75, 8'h65, 8'h6e, 8'h63, 8'h65};

    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // Expected characters at one window position, per pattern.
    typedef struct packed {
        logic [7:0] trig;
        logic [7:0] kw_begin;
        logic [7:0] kw_case;
        logic [7:0] kw_end;
        logic [7:0] mark;
    } exp_t;

    // Per-position compare results from one cell.
    typedef struct packed {
        logic trig;
        logic kw_begin;
        logic kw_case;
        logic kw_end;
        logic mark;
    } pos_hit_t;

    // Whole-pattern matches ending on the current character.
    typedef struct packed {
        logic trig;
        logic kw_begin;
        logic kw_case;
        logic kw_end;
        logic mark;
    } kw_hit_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       stmt_end;
        logic       stmt_keep;
        logic       tail_discarded;
    } result_t;

    function automatic exp_t exp_at(input int pos);
        exp_t e;
        e = '0;
        if (pos < TRIG_LEN)
            e.trig = KW_TRIGGER[8*pos +: 8];
        if (pos < BEGIN_LEN)
            e.kw_begin = KW_BEGIN[8*pos +: 8];
        if (pos < CASE_LEN)
            e.kw_case = KW_CASE[8*pos +: 8];
        if (pos < END_LEN)
            e.kw_end = KW_END[8*pos +: 8];
        if (pos < MARK_LEN)
            e.mark = TBL_MARKER[8*pos +: 8];
        return e;
    endfunction

endpackage

// ===== hdl/ssp_cell.sv =====
// One history cell: compares the character entering it and holds it for the next position.
module ssp_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic              flush,
    input  logic [7:0]        d,
    input  ssp_pkg::exp_t     expect_ch,
    output logic [7:0]        q,
    output ssp_pkg::pos_hit_t hit
);
    import ssp_pkg::*;

    logic [7:0] q_reg;
    logic [7:0] up;

    always_comb
    begin
        up = ((d >= 8'h61) && (d <= 8'h7a)) ? (d - 8'd32) : d;
        hit.trig     = (up == expect_ch.trig);
        hit.kw_begin = (up == expect_ch.kw_begin);
        hit.kw_case  = (up == expect_ch.kw_case);
        hit.kw_end   = (up == expect_ch.kw_end);
        hit.mark     = (d == expect_ch.mark);
    end

    // Advance on every accepted word; clear at script end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else if (shift_en)
            q_reg <= flush ? 8'h00 : d;
    end

    assign q = q_reg;

endmodule

// ===== hdl/ssp_ctrl.sv =====
// Statement tracker: quote state, nesting depth, blank and marker flags, close verdict.
module ssp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       ch,
    input  logic             last,
    input  ssp_pkg::kw_hit_t kw,
    output ssp_pkg::result_t res
);
    import ssp_pkg::*;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(DEPTH_LIMIT);
    localparam logic [LEN_W-1:0]   LEN_SAT   = LEN_W'(LEN_MAX);
    localparam logic [LEN_W-1:0]   LEN_MARK  = LEN_W'(HIST_LEN);

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               quote_reg, quote_next;
    logic               skip_reg, skip_next;
    logic               blank_reg, blank_next;
    logic               marker_reg, marker_next;

    logic [DEPTH_W-1:0] depth_kw;
    logic               skip_kw;
    logic               quote_now;
    logic               marker_now;
    logic               is_ws;
    logic               blank_now;
    logic               closes;

    always_comb
    begin
        depth_kw = depth_reg;
        skip_kw  = skip_reg;
        // Keywords end on distinct characters, so at most one hits per word.
        if (!quote_reg)
        begin
            if (kw.trig)
            begin
                if (depth_kw != DEPTH_MAX)
                    depth_kw = depth_kw + 1'b1;
                skip_kw = 1'b1;
            end
            if (kw.kw_begin && (depth_kw != '0))
            begin
                if (skip_kw)
                    skip_kw = 1'b0;
                else if (depth_kw != DEPTH_MAX)
                    depth_kw = depth_kw + 1'b1;
            end
            if (kw.kw_case && (depth_kw != '0) && (depth_kw != DEPTH_MAX))
                depth_kw = depth_kw + 1'b1;
            if (kw.kw_end && (depth_kw != '0))
                depth_kw = depth_kw - 1'b1;
        end

        quote_now  = quote_reg ^ (ch == CH_QUOTE);
        marker_now = marker_reg | ((len_reg >= LEN_MARK) && kw.mark);
        is_ws      = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        blank_now  = blank_reg && (is_ws || (ch == CH_SEMI));
        closes     = ((ch == CH_SEMI) || last) && (depth_kw == '0) && !quote_now;

        res.ch             = ch;
        res.stmt_end       = closes;
        res.stmt_keep      = closes && !(blank_now || marker_now);
        res.tail_discarded = last && !closes;

        depth_next  = depth_kw;
        skip_next   = skip_kw;
        quote_next  = quote_now;
        marker_next = marker_now;
        blank_next  = blank_reg && is_ws;
        len_next    = (len_reg != LEN_SAT) ? (len_reg + 1'b1) : len_reg;
        if (last)
        begin
            depth_next  = '0;
            skip_next   = 1'b0;
            quote_next  = 1'b0;
            marker_next = 1'b0;
            blank_next  = 1'b1;
            len_next    = '0;
        end
        else if (closes)
        begin
            marker_next = 1'b0;
            blank_next  = 1'b1;
            len_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            len_reg    <= '0;
            quote_reg  <= 1'b0;
            skip_reg   <= 1'b0;
            blank_reg  <= 1'b1;
            marker_reg <= 1'b0;
        end
        else if (accept)
        begin
            depth_reg  <= depth_next;
            len_reg    <= len_next;
            quote_reg  <= quote_next;
            skip_reg   <= skip_next;
            blank_reg  <= blank_next;
            marker_reg <= marker_next;
        end
    end

`ifndef SYNTH
    a_end_xor_tail: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(res.stmt_end && res.tail_discarded))
        else $error("statement close and tail discard on the same word");

    a_keep_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.stmt_keep |-> res.stmt_end)
        else $error("keep verdict without a statement close");

    a_script_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> (depth_reg == '0) && !quote_reg && !skip_reg
                            && blank_reg && !marker_reg && (len_reg == '0))
        else $error("state not cleared after script end");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.stmt_end |=> (len_reg == '0) && blank_reg && !marker_reg)
        else $error("statement flags not cleared after close");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("nesting depth above limit");
`endif

endmodule

// ===== hdl/sql_script_statement_splitter.sv =====
// Top level: character history chain, statement tracker and output skid stage.
// Accepted words are registered in the output register or, on a stall, the skid.
// Throughput: one character per cycle while s_tready is high; all keyword and marker
// matches are parallel compares along the 27-cell history chain, with the tracker
// updating once per word. The output register plus skid keep s_tready high until the
// skid fills. Reset clears the history, all tracking state and both entries.
module sql_script_statement_splitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // script_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] ch_out
    output logic       m_tlast,   // stmt_end
    output logic [1:0] m_tuser    // [0] stmt_keep, [1] tail_discarded
);
    import ssp_pkg::*;

    logic [7:0]       win [0:HIST_LEN];
    pos_hit_t         pos_hit [0:HIST_LEN-1];
    logic [HIST_LEN-1:0] trig_v, begin_v, case_v, end_v, mark_v;
    kw_hit_t          kw;
    result_t          res;
    logic             accept;

    result_t          out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;
    logic             out_take;

    assign accept = s_tvalid && s_tready;
    assign win[0] = s_tdata;

    genvar j;
    generate
        for (j = 0; j < HIST_LEN; j++)
        begin : g_cell
            ssp_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (accept),
                .flush     (s_tlast),
                .d         (win[j]),
                .expect_ch (exp_at(j)),
                .q         (win[j+1]),
                .hit       (pos_hit[j])
            );
            assign trig_v[j]  = pos_hit[j].trig;
            assign begin_v[j] = pos_hit[j].kw_begin;
            assign case_v[j]  = pos_hit[j].kw_case;
            assign end_v[j]   = pos_hit[j].kw_end;
            assign mark_v[j]  = pos_hit[j].mark;
        end
    endgenerate

    always_comb
    begin
        kw.trig     = &trig_v[TRIG_LEN-1:0];
        kw.kw_begin = &begin_v[BEGIN_LEN-1:0];
        kw.kw_case  = &case_v[CASE_LEN-1:0];
        kw.kw_end   = &end_v[END_LEN-1:0];
        // Oldest marker character sits one past the chain's last compare.
        kw.mark     = (&mark_v) && (win[HIST_LEN] == TBL_MARKER[8*HIST_LEN +: 8]);
    end

    ssp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (s_tdata),
        .last   (s_tlast),
        .kw     (kw),
        .res    (res)
    );

    assign s_tready = !skid_valid_reg;
    assign out_take = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res;
        end
        else if (accept)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.ch;
    assign m_tlast  = out_reg.stmt_end;
    assign m_tuser  = {out_reg.tail_discarded, out_reg.stmt_keep};

endmodule
